@@ rtl/scalar_muladd_mod_l_top_defines.svh @@
// assertion macros for the scalar multiply-add mod l block
// used by scalar_muladd_mod_l_top; needs clk and rst_n in scope
`ifndef SCALAR_MULADD_MOD_L_TOP_DEFINES_SVH
`define SCALAR_MULADD_MOD_L_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SCMAD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scmad check failed");

// next-cycle implication, checked out of reset
`define SCMAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scmad check failed");

`endif

@@ rtl/scmad_pkg.sv @@
// shared types and constants for the scalar multiply-add mod l block
// no dependencies
package scmad_pkg;

  // group order l = 2^252 + 27742317777372353535851937790883648493
  localparam logic [255:0] ORDER_L =
    256'h1000000000000000000000000000000014def9dea2f79cd65812631a5cf5d3ed;

  localparam int RES_W = 253;
  localparam int OP_W  = 256;

  // modular add cell operations
  localparam logic [1:0] MODE_DOUBLE = 2'd0;
  localparam logic [1:0] MODE_ADD_A  = 2'd1;
  localparam logic [1:0] MODE_ADD_C  = 2'd2;

  // operands before reduction
  typedef struct packed {
    logic [OP_W-1:0] a;
    logic [OP_W-1:0] b;
    logic [OP_W-1:0] c;
  } pre_t;

  // operands after reduction plus running residue
  typedef struct packed {
    logic [RES_W-1:0] r;
    logic [RES_W-1:0] a;
    logic [RES_W-1:0] c;
    logic [OP_W-1:0]  b;
  } stage_t;

  // output buffer status
  typedef struct packed {
    logic [1:0] count;
    logic       push;
  } buf_stat_t;

endpackage

@@ rtl/scmad_reduce_cell.sv @@
// one conditional subtract of l shifted by SHIFT, on a and c
// depends on scmad_pkg
module scmad_reduce_cell #(
  parameter int SHIFT = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  scmad_pkg::pre_t in_stage,
  output logic            out_valid,
  output scmad_pkg::pre_t out_stage
);
  import scmad_pkg::*;

  localparam logic [OP_W-1:0] LK = ORDER_L << SHIFT;

  logic            valid_r;
  pre_t            stage_r;
  pre_t            stage_nxt;
  logic [OP_W:0]   da;
  logic [OP_W:0]   dc;

  always_comb begin
    da = {1'b0, in_stage.a} - {1'b0, LK};
    dc = {1'b0, in_stage.c} - {1'b0, LK};
    stage_nxt   = in_stage;
    stage_nxt.a = da[OP_W] ? in_stage.a : da[OP_W-1:0];
    stage_nxt.c = dc[OP_W] ? in_stage.c : dc[OP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;
endmodule

@@ rtl/scmad_modadd_cell.sv @@
// one modular add step: r <- r + x mod l, x picked by MODE
// depends on scmad_pkg
module scmad_modadd_cell #(
  parameter logic [1:0] MODE = scmad_pkg::MODE_DOUBLE,
  parameter int         BIT  = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  scmad_pkg::stage_t in_stage,
  output logic              out_valid,
  output scmad_pkg::stage_t out_stage
);
  import scmad_pkg::*;

  localparam logic [RES_W-1:0] LR = ORDER_L[RES_W-1:0];

  logic             valid_r;
  stage_t           stage_r;
  stage_t           stage_nxt;
  logic [RES_W-1:0] x;
  logic [RES_W:0]   s;
  logic [RES_W+1:0] d;

  always_comb begin
    unique case (MODE)
      MODE_DOUBLE: x = in_stage.r;
      MODE_ADD_A:  x = in_stage.b[BIT] ? in_stage.a : '0;
      MODE_ADD_C:  x = in_stage.c;
      default:     x = '0;
    endcase
    s = {1'b0, in_stage.r} + {1'b0, x};
    d = {1'b0, s} - {2'b00, LR};
    stage_nxt   = in_stage;
    stage_nxt.r = d[RES_W+1] ? s[RES_W-1:0] : d[RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_stage = stage_r;
endmodule

@@ rtl/scmad_out_buf.sv @@
// two-entry result buffer between the cell chain and the output port
// depends on scmad_pkg
module scmad_out_buf (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [scmad_pkg::RES_W-1:0]  push_data,
  input  logic                         pop_ready,
  output logic                         pop_valid,
  output logic [scmad_pkg::RES_W-1:0]  pop_data,
  output logic                         has_room,
  output scmad_pkg::buf_stat_t         stat
);
  import scmad_pkg::*;

  logic [RES_W-1:0] ent_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;
  logic             pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = ent_r[rd_ptr_r];
  assign has_room  = (count_r != 2'd2);

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  assign stat.count = count_r;
  assign stat.push  = push;
endmodule

@@ rtl/scalar_muladd_mod_l_top.sv @@
// (a*b + c) mod l for the ed25519 group order l, fully pipelined.
// An operand beat enters every cycle while the result buffer has room. Its
// result passes through 517 cell stages and is then written into the result
// buffer, from which it is offered on the output. Four reduce cells bring a
// and c below l by conditional subtraction of 8l, 4l, 2l and l. A chain of
// 512 modular add cells then walks b from its top bit down, doubling the
// residue and adding a when the bit is set, and a last cell adds c. Each
// cell does one 254-bit add and one compare-subtract, so the chain length,
// not any loop, sets the latency. A two-entry buffer at the output keeps
// accepting input while a finished result waits; the chain stalls as a
// whole only when both entries are taken. Depends on scmad_pkg, the reduce
// cell, modular add cell and output buffer modules, and the defines header.
`include "scalar_muladd_mod_l_top_defines.svh"

module scalar_muladd_mod_l_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_a_word0,
  input  logic [63:0] in_a_word1,
  input  logic [63:0] in_a_word2,
  input  logic [63:0] in_a_word3,
  input  logic [63:0] in_b_word0,
  input  logic [63:0] in_b_word1,
  input  logic [63:0] in_b_word2,
  input  logic [63:0] in_b_word3,
  input  logic [63:0] in_c_word0,
  input  logic [63:0] in_c_word1,
  input  logic [63:0] in_c_word2,
  input  logic [63:0] in_c_word3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_sum_word0,
  output logic [63:0] out_sum_word1,
  output logic [63:0] out_sum_word2,
  output logic [60:0] out_sum_word3
);
  import scmad_pkg::*;

  localparam int N_RED = 4;
  localparam int N_ADD = 2 * OP_W;

  // whole chain advances together; decided from registered buffer state
  logic      en;
  pre_t      pre_s   [N_RED+1];
  logic      pre_v   [N_RED+1];
  stage_t    add_s   [N_ADD+2];
  logic      add_v   [N_ADD+2];
  logic [RES_W-1:0] res;
  buf_stat_t bstat;

  assign in_ready = en;

  assign pre_v[0]   = in_valid;
  assign pre_s[0].a = {in_a_word3, in_a_word2, in_a_word1, in_a_word0};
  assign pre_s[0].b = {in_b_word3, in_b_word2, in_b_word1, in_b_word0};
  assign pre_s[0].c = {in_c_word3, in_c_word2, in_c_word1, in_c_word0};

  // reduce a and c below l, largest multiple first
  for (genvar k = 0; k < N_RED; k++) begin : g_red
    scmad_reduce_cell #(.SHIFT(N_RED - 1 - k)) u_red (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (pre_v[k]),
      .in_stage  (pre_s[k]),
      .out_valid (pre_v[k+1]),
      .out_stage (pre_s[k+1])
    );
  end

  // residue starts at zero; a and c are now below 2^253
  assign add_v[0]   = pre_v[N_RED];
  assign add_s[0].r = '0;
  assign add_s[0].a = pre_s[N_RED].a[RES_W-1:0];
  assign add_s[0].c = pre_s[N_RED].c[RES_W-1:0];
  assign add_s[0].b = pre_s[N_RED].b;

  // even cells double, odd cells add a for bit (OP_W-1 - j/2) of b
  for (genvar j = 0; j < N_ADD; j++) begin : g_add
    scmad_modadd_cell #(
      .MODE ((j % 2 == 0) ? MODE_DOUBLE : MODE_ADD_A),
      .BIT  (OP_W - 1 - j / 2)
    ) u_add (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (add_v[j]),
      .in_stage  (add_s[j]),
      .out_valid (add_v[j+1]),
      .out_stage (add_s[j+1])
    );
  end

  // fold in the addend
  scmad_modadd_cell #(.MODE(MODE_ADD_C), .BIT(0)) u_addc (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (add_v[N_ADD]),
    .in_stage  (add_s[N_ADD]),
    .out_valid (add_v[N_ADD+1]),
    .out_stage (add_s[N_ADD+1])
  );

  scmad_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (add_v[N_ADD+1] && en),
    .push_data (add_s[N_ADD+1].r),
    .pop_ready (out_ready),
    .pop_valid (out_valid),
    .pop_data  (res),
    .has_room  (en),
    .stat      (bstat)
  );

  assign out_sum_word0 = res[63:0];
  assign out_sum_word1 = res[127:64];
  assign out_sum_word2 = res[191:128];
  assign out_sum_word3 = res[252:192];

  // buffer never overfills
  `SCMAD_ASSERT_NOW(a_buf_bound, 1'b1, bstat.count != 2'd3)
  // a full buffer stops the input side
  `SCMAD_ASSERT_NOW(a_full_stalls, bstat.count == 2'd2, !in_ready)
  // a beat pushed into an empty buffer is offered next cycle
  `SCMAD_ASSERT_NEXT(a_push_shows, bstat.push && bstat.count == 2'd0, out_valid)
  // the result offered is always reduced below l
  `SCMAD_ASSERT_NOW(a_canonical, add_v[N_ADD+1],
                    add_s[N_ADD+1].r < ORDER_L[RES_W-1:0])
endmodule
